>>> rtl/json_string_unescape_utf8_defines.svh
// assertion macros shared by the json string unescaper rtl
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, checked while out of reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

>>> rtl/jsu_pkg.sv
// shared types and constants of the json string unescaper
`default_nettype none

package jsu_pkg;

    localparam int BURST_MAX = 4;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_CLOSED  = 3'd1,
        KIND_NOQUOTE = 3'd2,
        KIND_BADHEX  = 3'd3,
        KIND_UNTERM  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } res_item_t;

    typedef struct packed {
        logic [2:0]                      n;
        res_item_t [BURST_MAX-1:0]       item;
    } burst_t;

endpackage

`default_nettype wire

>>> rtl/jsu_stream_if.sv
// request channels of the json string unescaper
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       run_last;

    modport source (output valid, output out_byte, output kind, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input kind, input run_last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/jsu_decode.sv
// per-byte decoder: string state and the results one byte causes
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       advance,
    output burst_t          burst
);

    typedef enum logic [2:0] {
        MODE_AWAIT  = 3'd0,
        MODE_STRING = 3'd1,
        MODE_ESCAPE = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_SKIP   = 3'd4
    } mode_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;

    logic              term;
    logic [1:0]        main_n;
    logic              extra;
    kind_t             extra_kind;
    logic              hex_ok;
    logic [3:0]        hex_val;
    logic [15:0]       cp;
    res_item_t [BURST_MAX-1:0] items;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] d;
        unique case (c)
            8'h62:   d = 8'h08;
            8'h66:   d = 8'h0c;
            8'h6e:   d = 8'h0a;
            8'h72:   d = 8'h0d;
            8'h74:   d = 8'h09;
            default: d = c;
        endcase
        return d;
    endfunction

    assign {hex_ok, hex_val} = hex_digit(in_byte);
    assign cp = {code_accum_reg[11:0], hex_val};

    always_comb
    begin
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;
        term            = 1'b0;
        main_n          = 2'd0;
        extra           = 1'b0;
        extra_kind      = KIND_UNTERM;
        items           = '0;

        unique case (mode_reg)
            MODE_AWAIT:
            begin
                if (in_byte == CH_QUOTE) begin
                    mode_next = MODE_STRING;
                end else begin
                    items[0].kind = KIND_NOQUOTE;
                    main_n        = 2'd1;
                    term          = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (in_byte == CH_QUOTE) begin
                    items[0].kind = KIND_CLOSED;
                    main_n        = 2'd1;
                    term          = 1'b1;
                end else if (in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    items[0].data = in_byte;
                    main_n        = 2'd1;
                end
            end
            MODE_ESCAPE:
            begin
                if (in_byte == CH_U) begin
                    mode_next       = MODE_HEX;
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'd0;
                end else begin
                    mode_next     = MODE_STRING;
                    items[0].data = esc_map(in_byte);
                    main_n        = 2'd1;
                end
            end
            MODE_HEX:
            begin
                if (!hex_ok) begin
                    items[0].kind = KIND_BADHEX;
                    main_n        = 2'd1;
                    term          = 1'b1;
                end else begin
                    code_accum_next = cp;
                    if (hex_count_reg == 2'd3) begin
                        hex_count_next = 2'd0;
                        mode_next      = MODE_STRING;
                        if (cp <= 16'h007f) begin
                            items[0].data = cp[7:0];
                            main_n        = 2'd1;
                        end else if (cp <= 16'h07ff) begin
                            items[0].data = {3'b110, cp[10:6]};
                            items[1].data = {2'b10, cp[5:0]};
                            main_n        = 2'd2;
                        end else begin
                            items[0].data = {4'b1110, cp[15:12]};
                            items[1].data = {2'b10, cp[11:6]};
                            items[2].data = {2'b10, cp[5:0]};
                            main_n        = 2'd3;
                        end
                    end else begin
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (in_last) begin
            if (!term) begin
                if (mode_next == MODE_STRING || mode_next == MODE_ESCAPE) begin
                    extra      = 1'b1;
                    extra_kind = KIND_UNTERM;
                end else if (mode_next == MODE_HEX) begin
                    extra      = 1'b1;
                    extra_kind = KIND_BADHEX;
                end
            end
            mode_next       = MODE_AWAIT;
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
        end else if (term) begin
            mode_next       = MODE_SKIP;
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
        end

        for (int i = 0; i < BURST_MAX; i++) begin
            if (extra && main_n == i[1:0]) begin
                items[i].data = 8'd0;
                items[i].kind = extra_kind;
            end
        end
    end

    assign burst.item = items;
    assign burst.n    = {1'b0, main_n} + {2'b00, extra};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_AWAIT;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= 16'd0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
        end
    end

    // digit count only lives inside a unicode escape
    `JSU_ASSERT_NOW(a_hex_count_mode, mode_reg != MODE_HEX, hex_count_reg == 2'd0)
    // a terminal status in mid-frame drops into discarding
    `JSU_ASSERT_NEXT(a_term_skip, advance && term && !in_last, mode_reg == MODE_SKIP)
    // the frame's last byte always restarts the frame
    `JSU_ASSERT_NEXT(a_last_restart, advance && in_last, mode_reg == MODE_AWAIT)

endmodule

`default_nettype wire

>>> rtl/jsu_burst.sv
// result buffer: holds one byte's results and hands them out one a cycle while pop is held
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"

module jsu_burst
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  burst_t    burst,
    input  wire logic pop,
    output logic      free,
    output logic      head_valid,
    output res_item_t head,
    output logic      head_last
);

    logic [2:0]                count_reg, count_next;
    res_item_t [BURST_MAX-1:0] slot_reg, slot_next;

    assign head_valid = (count_reg != 3'd0);
    assign head       = slot_reg[0];
    assign head_last  = (count_reg == 3'd1);
    assign free       = (count_reg == 3'd0) || (count_reg == 3'd1 && pop);

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (load) begin
            count_next = burst.n;
            slot_next  = burst.item;
        end else if (pop) begin
            count_next = count_reg - 3'd1;
            for (int i = 0; i < BURST_MAX - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    `JSU_ASSERT_NOW(a_count_max, 1'b1, count_reg <= 3'd4)
    // a new burst never overwrites results still owed
    `JSU_ASSERT_NOW(a_load_free, load, count_reg == 3'd0 || (count_reg == 3'd1 && pop))
    // status results carry a zero byte
    `JSU_ASSERT_NOW(a_status_zero, head_valid && head.kind != KIND_DATA, head.data == 8'd0)

endmodule

`default_nettype wire

>>> rtl/json_string_unescape_utf8.sv
// top level of the json string unescaper with utf-8 output
//
//  channel  dir  payload                     handshake
//  in_ch    in   in_byte[8] in_last          valid/ready
//  out_ch   out  out_byte[8] kind[3] run_last valid/ready
//
// one byte enters per cycle while the result buffer is free; its results
// leave one per cycle while out_ch.ready is held, so a byte that yields n
// results (n up to 4) holds back the next byte until its last result leaves
// reset clears the string state and empties the input and result registers
// a one-entry input register lets the input side take one request while the
// results of a burst wait on out_ch.ready
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    jsu_in_if.sink   in_ch,
    jsu_out_if.source out_ch
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic      load;
    logic      pop;
    logic      free;
    logic      head_valid;
    logic      head_last;
    res_item_t head;
    burst_t    burst;

    assign load        = in_valid_reg && free;
    assign in_ch.ready = !in_valid_reg || free;
    assign pop         = head_valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ch.ready) begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid) begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.in_last;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .advance (load),
        .burst   (burst)
    );

    jsu_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .burst      (burst),
        .pop        (pop),
        .free       (free),
        .head_valid (head_valid),
        .head       (head),
        .head_last  (head_last)
    );

    assign out_ch.valid    = head_valid;
    assign out_ch.out_byte = head.data;
    assign out_ch.kind     = head.kind;
    assign out_ch.run_last = head_last;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench of the json string unescaper with utf-8 output
`default_nettype none

module tb_top
    import jsu_pkg::*;
();

    localparam int LIMIT = 200000;
    localparam int RANDOM_REQUESTS = 390;
    localparam int HOLD_STRETCH = 80;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U = 8'h75;

    typedef enum logic [2:0] {
        SCAN_AWAIT,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_HEX,
        SCAN_SKIP
    } scan_t;

    typedef struct {
        logic [7:0] data;
        kind_t      kind;
        logic       run_last;
    } result_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         typed;
        int         nexp;
        logic [7:0] tdata;
        kind_t      tkind;
    } req_t;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    scan_t       scan_mode;
    logic [1:0]  hex_seen;
    logic [15:0] code_point;

    result_t expected_q [$];
    result_t decoded [$];
    req_t    frame_q [$];
    req_t    directed [$];

    int errors;
    int cycles;
    int results_seen;
    int frames_sent;
    int requests_sent;
    int hold_cycles;
    bit fast_sender;
    bit fast_receiver;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d results pending", cycles,
                     expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("tb: mismatch at cycle %0d: %s", cycles, msg);
    endtask

    function automatic void add_result(input logic [7:0] data, input kind_t kind);
        decoded.insert(decoded.size(), result_t'{data, kind, 1'b0});
    endfunction

    function automatic void queue_expected(input result_t r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void append_row(input req_t r);
        frame_q.insert(frame_q.size(), r);
    endfunction

    function automatic void add_directed(input req_t r);
        directed.insert(directed.size(), r);
    endfunction

    // decode one request into the results it yields
    function automatic void decode_request(input logic [7:0] c, input logic last);
        bit term;
        int v;
        logic [7:0] d;
        term = 1'b0;
        decoded.delete();
        case (scan_mode)
            SCAN_AWAIT:
            begin
                if (c == CH_QUOTE)
                    scan_mode = SCAN_STRING;
                else
                begin
                    add_result(8'h00, KIND_NOQUOTE);
                    term = 1'b1;
                end
            end
            SCAN_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    add_result(8'h00, KIND_CLOSED);
                    term = 1'b1;
                end
                else if (c == CH_BSLASH)
                    scan_mode = SCAN_ESCAPE;
                else
                    add_result(c, KIND_DATA);
            end
            SCAN_ESCAPE:
            begin
                scan_mode = SCAN_STRING;
                if (c == CH_U)
                begin
                    scan_mode = SCAN_HEX;
                    hex_seen = 2'd0;
                    code_point = 16'h0000;
                end
                else
                begin
                    case (c)
                        8'h62: d = 8'h08;
                        8'h66: d = 8'h0c;
                        8'h6e: d = 8'h0a;
                        8'h72: d = 8'h0d;
                        8'h74: d = 8'h09;
                        default: d = c;
                    endcase
                    add_result(d, KIND_DATA);
                end
            end
            SCAN_HEX:
            begin
                if (c >= 8'h30 && c <= 8'h39)
                    v = c - 8'h30;
                else if (c >= 8'h61 && c <= 8'h66)
                    v = c - 8'h61 + 10;
                else if (c >= 8'h41 && c <= 8'h46)
                    v = c - 8'h41 + 10;
                else
                    v = -1;
                if (v < 0)
                begin
                    add_result(8'h00, KIND_BADHEX);
                    term = 1'b1;
                end
                else
                begin
                    code_point = {code_point[11:0], 4'(v)};
                    if (hex_seen == 2'd3)
                    begin
                        hex_seen = 2'd0;
                        scan_mode = SCAN_STRING;
                        if (code_point <= 16'h007f)
                            add_result(code_point[7:0], KIND_DATA);
                        else if (code_point <= 16'h07ff)
                        begin
                            add_result({3'b110, code_point[10:6]}, KIND_DATA);
                            add_result({2'b10, code_point[5:0]}, KIND_DATA);
                        end
                        else
                        begin
                            add_result({4'b1110, code_point[15:12]}, KIND_DATA);
                            add_result({2'b10, code_point[11:6]}, KIND_DATA);
                            add_result({2'b10, code_point[5:0]}, KIND_DATA);
                        end
                    end
                    else
                        hex_seen = hex_seen + 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            if (!term)
            begin
                if (scan_mode == SCAN_STRING || scan_mode == SCAN_ESCAPE)
                    add_result(8'h00, KIND_UNTERM);
                else if (scan_mode == SCAN_HEX)
                    add_result(8'h00, KIND_BADHEX);
            end
            scan_mode = SCAN_AWAIT;
            hex_seen = 2'd0;
            code_point = 16'h0000;
        end
        else if (term)
        begin
            scan_mode = SCAN_SKIP;
            hex_seen = 2'd0;
            code_point = 16'h0000;
        end

        if (decoded.size() > 0)
            decoded[decoded.size()-1].run_last = 1'b1;
    endfunction

    function automatic req_t plain_row(input logic [7:0] b, input logic last);
        return req_t'{b, last, 1'b0, 0, 8'h00, KIND_DATA};
    endfunction

    function automatic req_t typed_row(input logic [7:0] b, input logic last, input int nexp,
                                       input logic [7:0] data, input kind_t kind);
        return req_t'{b, last, 1'b1, nexp, data, kind};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // one random frame: mostly well formed strings, the rest broken or noise
    function automatic void make_frame();
        int shape;
        int tokens;
        int t;
        int k;
        logic [7:0] b;
        logic [15:0] cp;
        frame_q.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            append_row(plain_row(b, 1'b0));
            repeat ($urandom_range(0, 3))
                append_row(plain_row(8'($urandom_range(0, 255)), 1'b0));
        end
        else
        begin
            append_row(plain_row(CH_QUOTE, 1'b0));
            tokens = $urandom_range(0, 8);
            for (t = 0; t < tokens; t++)
            begin
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        append_row(plain_row(b, 1'b0));
                    end
                    2:
                    begin
                        append_row(plain_row(CH_BSLASH, 1'b0));
                        case ($urandom_range(0, 9))
                            0: b = 8'h62;
                            1: b = 8'h66;
                            2: b = 8'h6e;
                            3: b = 8'h72;
                            4: b = 8'h74;
                            5: b = CH_QUOTE;
                            6: b = CH_BSLASH;
                            7: b = 8'h2f;
                            default:
                                do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                        endcase
                        append_row(plain_row(b, 1'b0));
                    end
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0: cp = 16'($urandom_range(0, 16'h007f));
                            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
                            2: cp = 16'($urandom_range(16'h0800, 16'hffff));
                            3: cp = 16'($urandom_range(16'hd800, 16'hdfff));
                            4: cp = $urandom_range(0, 1) ? 16'h007f : 16'h0080;
                            default:
                            begin
                                case ($urandom_range(0, 3))
                                    0: cp = 16'h0000;
                                    1: cp = 16'h07ff;
                                    2: cp = 16'h0800;
                                    default: cp = 16'hffff;
                                endcase
                            end
                        endcase
                        append_row(plain_row(CH_BSLASH, 1'b0));
                        append_row(plain_row(CH_U, 1'b0));
                        for (k = 3; k >= 0; k--)
                            append_row(plain_row(hex_char(cp[k*4 +: 4]), 1'b0));
                    end
                endcase
            end
            shape = $urandom_range(0, 99);
            if (shape < 70)
            begin
                append_row(plain_row(CH_QUOTE, 1'b0));
                repeat ($urandom_range(0, 2))
                    append_row(plain_row(8'($urandom_range(0, 255)), 1'b0));
            end
            else if (shape < 80)
            begin
                if ($urandom_range(0, 1))
                    append_row(plain_row(CH_BSLASH, 1'b0));
            end
            else
            begin
                append_row(plain_row(CH_BSLASH, 1'b0));
                append_row(plain_row(CH_U, 1'b0));
                repeat ($urandom_range(0, 3))
                    append_row(plain_row(hex_char(4'($urandom_range(0, 15))), 1'b0));
                if (shape < 90)
                begin
                    do b = 8'($urandom_range(0, 255));
                    while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                           (b >= 8'h61 && b <= 8'h66));
                    append_row(plain_row(b, 1'b0));
                    repeat ($urandom_range(0, 2))
                        append_row(plain_row(8'($urandom_range(0, 255)), 1'b0));
                end
            end
        end
        frame_q[frame_q.size()-1].last = 1'b1;
    endfunction

    task automatic drive_request(input req_t r, input int gap);
        repeat (gap) @(negedge clk);
        in_ch.in_byte = r.b;
        in_ch.in_last = r.last;
        in_ch.valid = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        decode_request(r.b, r.last);
        if (r.typed)
        begin
            if (r.nexp > 0)
                queue_expected(result_t'{r.tdata, r.tkind, 1'b1});
        end
        else
        begin
            foreach (decoded[k])
                queue_expected(decoded[k]);
        end
        requests_sent++;
        if (r.last)
            frames_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() > 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // result side: random ready gaps, long hold-off on request, field compare
    initial
    begin
        int gap;
        result_t e;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = fast_receiver ? 0 : $urandom_range(0, 9);
            gap += hold_cycles;
            hold_cycles = 0;
            if (gap > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected result byte %02h kind %0d last %0b",
                                          out_ch.out_byte, out_ch.kind, out_ch.run_last));
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.out_byte !== e.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_ch.out_byte, e.data));
                if (out_ch.kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, e.kind));
                if (out_ch.run_last !== e.run_last)
                    report_mismatch($sformatf("run_last %0b, expected %0b",
                                              out_ch.run_last, e.run_last));
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int rand_sent;
        bit hold_done;
        bit pause_done;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready = 1'b0;
        fast_sender = 1'b0;
        fast_receiver = 1'b0;
        hold_cycles = 0;
        errors = 0;
        cycles = 0;
        results_seen = 0;
        frames_sent = 0;
        requests_sent = 0;
        rand_sent = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        scan_mode = SCAN_AWAIT;
        hex_seen = 2'd0;
        code_point = 16'h0000;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // missing quote, then discard through the last byte
        add_directed(typed_row(8'h41, 1'b0, 1, 8'h00, KIND_NOQUOTE));
        add_directed(typed_row(8'hff, 1'b1, 0, 8'h00, KIND_DATA));
        // frame of only the opening quote
        add_directed(typed_row(CH_QUOTE, 1'b1, 1, 8'h00, KIND_UNTERM));
        // byte extremes, two-byte code point, closing quote, trailing byte
        add_directed(plain_row(CH_QUOTE, 1'b0));
        add_directed(typed_row(8'h00, 1'b0, 1, 8'h00, KIND_DATA));
        add_directed(typed_row(8'hff, 1'b0, 1, 8'hff, KIND_DATA));
        add_directed(plain_row(CH_BSLASH, 1'b0));
        add_directed(plain_row(CH_U, 1'b0));
        add_directed(plain_row(8'h30, 1'b0));
        add_directed(plain_row(8'h37, 1'b0));
        add_directed(plain_row(8'h46, 1'b0));
        add_directed(plain_row(8'h66, 1'b0));
        add_directed(typed_row(CH_QUOTE, 1'b0, 1, 8'h00, KIND_CLOSED));
        add_directed(typed_row(8'h78, 1'b1, 0, 8'h00, KIND_DATA));
        // surrogate half as the last byte: three data bytes then unterminated
        add_directed(plain_row(CH_QUOTE, 1'b0));
        add_directed(plain_row(CH_BSLASH, 1'b0));
        add_directed(plain_row(CH_U, 1'b0));
        add_directed(plain_row(8'h44, 1'b0));
        add_directed(plain_row(8'h38, 1'b0));
        add_directed(plain_row(8'h30, 1'b0));
        add_directed(plain_row(8'h30, 1'b1));
        // non-hex digit inside the unicode escape
        add_directed(plain_row(CH_QUOTE, 1'b0));
        add_directed(plain_row(CH_BSLASH, 1'b0));
        add_directed(plain_row(CH_U, 1'b0));
        add_directed(typed_row(8'h67, 1'b0, 1, 8'h00, KIND_BADHEX));
        add_directed(typed_row(8'h7a, 1'b1, 0, 8'h00, KIND_DATA));
        // frame ends right after a backslash
        add_directed(plain_row(CH_QUOTE, 1'b0));
        add_directed(typed_row(CH_BSLASH, 1'b1, 1, 8'h00, KIND_UNTERM));

        foreach (directed[i])
            drive_request(directed[i], $urandom_range(0, 9));
        wait_drained();

        while (rand_sent < RANDOM_REQUESTS)
        begin
            make_frame();
            fast_sender = ($urandom_range(0, 5) == 0);
            fast_receiver = ($urandom_range(0, 5) == 0);
            if (!hold_done && rand_sent >= 150)
            begin
                hold_done = 1'b1;
                fast_receiver = 1'b0;
                hold_cycles = HOLD_STRETCH;
            end
            if (!pause_done && rand_sent >= 290)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            foreach (frame_q[i])
            begin
                drive_request(frame_q[i],
                              (fast_sender || hold_cycles > 0) ? 0 : $urandom_range(0, 9));
                rand_sent++;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("tb: ran %0d requests in %0d frames, directed and random, with stalls",
                 requests_sent, frames_sent);
        $display("tb: compared %0d results, %0d mismatches", results_seen, errors);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
